@@ rtl/alsd_pkg.sv @@
// Shared constants, types and register indexes for the analog level slot detector.
package alsd_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int WIN_BITS    = 3;
    localparam int WINDOW      = 1 << WIN_BITS;
    localparam int TOTAL_BITS  = SAMPLE_BITS + WIN_BITS;
    localparam int MAX_SLOTS   = 32;
    localparam int SLOT_BITS   = 5;
    localparam int COUNT_BITS  = SLOT_BITS + 1;
    localparam int STEP_BITS   = 12;
    localparam int GUARD_BITS  = 8;
    localparam int CONF_BITS   = 4;
    localparam int BASE_BITS   = 18;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 12;
    localparam int IN_TDATA_BITS  = 16;
    localparam int OUT_TDATA_BITS = 24;

    localparam logic [CFG_ADDR_BITS-1:0] REG_SLOT_COUNT     = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_STEP_PER_SLOT  = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_LEVEL_OFFSET   = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_GUARD_BAND     = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_CONFIRM_NEEDED = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SMOOTHING_MODE = 3'd5;

    localparam logic [COUNT_BITS-1:0]  RST_SLOT_COUNT     = 6'd1;
    localparam logic [STEP_BITS-1:0]   RST_STEP_PER_SLOT  = 12'd1;
    localparam logic [SAMPLE_BITS-1:0] RST_LEVEL_OFFSET   = 12'd0;
    localparam logic [GUARD_BITS-1:0]  RST_GUARD_BAND     = 8'd4;
    localparam logic [CONF_BITS-1:0]   RST_CONFIRM_NEEDED = 4'd3;
    localparam logic                   RST_SMOOTHING_MODE = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILTER,
        ST_SETUP,
        ST_SEARCH,
        ST_DECIDE
    } t_state;

    typedef struct packed {
        logic load;
        logic prime;
        logic ema_sel;
    } t_flt_ctrl;

endpackage

@@ rtl/alsd_smoother.sv @@
// Sample ring with running total and exponential average; updates one sample per load.
module alsd_smoother
    import alsd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_flt_ctrl              i_ctrl,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic [SAMPLE_BITS-1:0] o_level
);

    logic [SAMPLE_BITS-1:0] r_ring [WINDOW];
    logic [WIN_BITS-1:0]    r_ptr;
    logic [TOTAL_BITS-1:0]  r_total;
    logic [SAMPLE_BITS-1:0] r_level;

    logic [TOTAL_BITS-1:0]  n_total;
    logic [SAMPLE_BITS:0]   ema_wide;
    logic [SAMPLE_BITS-1:0] n_level;

    always_comb begin
        n_total  = r_total - TOTAL_BITS'(r_ring[r_ptr]) + TOTAL_BITS'(i_sample);
        ema_wide = (SAMPLE_BITS+1)'(r_level) - (SAMPLE_BITS+1)'(r_level >> WIN_BITS)
                 + (SAMPLE_BITS+1)'(i_sample >> WIN_BITS);
        n_level  = i_ctrl.ema_sel ? ema_wide[SAMPLE_BITS-1:0]
                                  : n_total[TOTAL_BITS-1:WIN_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr   <= '0;
            r_total <= '0;
            r_level <= '0;
        end else if (i_ctrl.load) begin
            if (i_ctrl.prime) begin
                r_ptr   <= '0;
                r_total <= TOTAL_BITS'(i_sample) << WIN_BITS;
                r_level <= i_sample;
            end else begin
                r_ptr   <= r_ptr + 1'b1;
                r_total <= n_total;
                r_level <= n_level;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            if (i_ctrl.prime) begin
                for (int i = 0; i < WINDOW; i++) begin
                    r_ring[i] <= i_sample;
                end
            end else begin
                r_ring[r_ptr] <= i_sample;
            end
        end
    end

    assign o_level = r_level;

endmodule

@@ rtl/analog_level_slot_detector.sv @@
// Analog level slot detector: smoothing, guarded slot search and debounced commit.
// Steps per sample: filter, setup, search, decide. The search tries one slot a cycle (one compare
// unit) over the neighbor window, or all slots on the priming sample, and ends at the first match
// or past the window end. A new sample is taken only in idle, after decide; receiver stalls hold decide.
// Reset (synchronous, active low) restores register defaults and unprimed state;
// the first sample after reset primes the filters and searches all slots.
module analog_level_slot_detector
    import alsd_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_ADDR_BITS-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_wdata,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,   // [11:0] sample
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [OUT_TDATA_BITS-1:0] m_axis_tdata    // [4:0] active_slot, [5] slot_changed,
                                                      // [17:6] smoothed_value
);

    // configuration
    logic [COUNT_BITS-1:0]  r_slot_count;
    logic [STEP_BITS-1:0]   r_step;
    logic [SAMPLE_BITS-1:0] r_offset;
    logic [GUARD_BITS-1:0]  r_guard;
    logic [CONF_BITS-1:0]   r_confirm;
    logic                   r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= RST_SLOT_COUNT;
            r_step       <= RST_STEP_PER_SLOT;
            r_offset     <= RST_LEVEL_OFFSET;
            r_guard      <= RST_GUARD_BAND;
            r_confirm    <= RST_CONFIRM_NEEDED;
            r_mode       <= RST_SMOOTHING_MODE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_SLOT_COUNT:     r_slot_count <= i_cfg_wdata[COUNT_BITS-1:0];
                REG_STEP_PER_SLOT:  r_step       <= i_cfg_wdata[STEP_BITS-1:0];
                REG_LEVEL_OFFSET:   r_offset     <= i_cfg_wdata[SAMPLE_BITS-1:0];
                REG_GUARD_BAND:     r_guard      <= i_cfg_wdata[GUARD_BITS-1:0];
                REG_CONFIRM_NEEDED: r_confirm    <= i_cfg_wdata[CONF_BITS-1:0];
                REG_SMOOTHING_MODE: r_mode       <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    logic [COUNT_BITS-1:0] eff_count;
    logic [SLOT_BITS-1:0]  top_slot;
    logic [STEP_BITS-1:0]  eff_step;
    logic [CONF_BITS-1:0]  eff_confirm;

    always_comb begin
        if (r_slot_count == '0) begin
            eff_count = COUNT_BITS'(1);
        end else if (r_slot_count > COUNT_BITS'(MAX_SLOTS)) begin
            eff_count = COUNT_BITS'(MAX_SLOTS);
        end else begin
            eff_count = r_slot_count;
        end
        top_slot    = SLOT_BITS'(eff_count - 1'b1);
        eff_step    = (r_step == '0) ? STEP_BITS'(1) : r_step;
        eff_confirm = (r_confirm == '0) ? CONF_BITS'(1) : r_confirm;
    end

    // sequencer and datapath registers
    t_state r_state, n_state;
    logic                   r_primed;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [SLOT_BITS-1:0]   r_lo, r_hi;
    logic [COUNT_BITS-1:0]  r_slot;
    logic [BASE_BITS-1:0]   r_base;
    logic [SLOT_BITS-1:0]   r_cand;
    logic [SLOT_BITS-1:0]   r_proposed, r_committed;
    logic [CONF_BITS-1:0]   r_tally;
    logic                   r_out_valid;
    logic [SLOT_BITS-1:0]   r_out_slot;
    logic                   r_out_changed;
    logic [SAMPLE_BITS-1:0] r_out_value;

    t_flt_ctrl              flt_ctrl;
    logic [SAMPLE_BITS-1:0] level;

    alsd_smoother u_smoother (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (flt_ctrl),
        .i_sample (r_sample),
        .o_level  (level)
    );

    logic                 accept;
    logic                 out_free;
    logic                 decide_go;
    logic                 search_done;
    logic                 past_hi;
    logic                 hit;
    logic [BASE_BITS-1:0] level_w;
    logic [BASE_BITS-1:0] low_thr;
    logic [BASE_BITS-1:0] high_thr;
    logic [SLOT_BITS-1:0] clamp_slot;
    logic [SLOT_BITS-1:0] n_lo, n_hi;
    logic [SLOT_BITS-1:0] n_proposed;
    logic [CONF_BITS-1:0] n_tally;
    logic                 n_changed;

    // search compare unit
    always_comb begin
        level_w    = BASE_BITS'(level);
        low_thr    = (r_base >= BASE_BITS'(r_guard)) ? r_base - BASE_BITS'(r_guard) : '0;
        high_thr   = r_base + BASE_BITS'(eff_step) + BASE_BITS'(r_guard);
        past_hi    = r_slot > COUNT_BITS'(r_hi);
        hit        = !past_hi && (level_w >= low_thr) && (level_w < high_thr);
        clamp_slot = (level < r_offset) ? '0 : top_slot;
    end

    // neighbor window around the proposed slot, or all slots before priming
    always_comb begin
        if (!r_primed) begin
            n_lo = '0;
            n_hi = top_slot;
        end else begin
            n_lo = (r_proposed != '0) ? r_proposed - 1'b1 : '0;
            n_hi = (COUNT_BITS'(r_proposed) + 1'b1 < eff_count) ? r_proposed + 1'b1 : top_slot;
        end
    end

    // debounce
    always_comb begin
        n_proposed = r_proposed;
        n_tally    = r_tally;
        n_changed  = 1'b0;
        if (r_cand == r_proposed) begin
            if (r_tally < eff_confirm) begin
                n_tally = r_tally + 1'b1;
            end
        end else begin
            n_proposed = r_cand;
            n_tally    = CONF_BITS'(1);
        end
        if (n_tally >= eff_confirm && n_proposed != r_committed) begin
            n_changed = 1'b1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (accept) n_state = ST_FILTER;
            ST_FILTER: n_state = ST_SETUP;
            ST_SETUP:  n_state = ST_SEARCH;
            ST_SEARCH: if (search_done) n_state = ST_DECIDE;
            ST_DECIDE: if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_axis_tready    = (r_state == ST_IDLE);
        accept           = s_axis_tvalid && s_axis_tready;
        out_free         = !r_out_valid || m_axis_tready;
        decide_go        = (r_state == ST_DECIDE) && out_free;
        search_done      = (r_state == ST_SEARCH) && (past_hi || hit);
        flt_ctrl.load    = (r_state == ST_FILTER);
        flt_ctrl.prime   = !r_primed;
        flt_ctrl.ema_sel = r_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_primed    <= 1'b0;
            r_proposed  <= '0;
            r_committed <= '0;
            r_tally     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (decide_go) begin
                r_out_valid <= 1'b1;
                if (!r_primed) begin
                    r_primed    <= 1'b1;
                    r_proposed  <= r_cand;
                    r_committed <= r_cand;
                    r_tally     <= eff_confirm;
                end else begin
                    r_proposed <= n_proposed;
                    r_tally    <= n_tally;
                    if (n_changed) begin
                        r_committed <= n_proposed;
                    end
                end
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= s_axis_tdata[SAMPLE_BITS-1:0];
        end
        if (r_state == ST_FILTER) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
        if (r_state == ST_SETUP) begin
            r_slot <= COUNT_BITS'(r_lo);
            r_base <= BASE_BITS'(r_offset) + BASE_BITS'(eff_step) * BASE_BITS'(r_lo);
        end
        if (r_state == ST_SEARCH) begin
            if (past_hi) begin
                r_cand <= clamp_slot;
            end else if (hit) begin
                r_cand <= r_slot[SLOT_BITS-1:0];
            end else begin
                r_slot <= r_slot + 1'b1;
                r_base <= r_base + BASE_BITS'(eff_step);
            end
        end
        if (decide_go) begin
            r_out_value <= level;
            if (!r_primed) begin
                r_out_slot    <= r_cand;
                r_out_changed <= 1'b0;
            end else begin
                r_out_slot    <= n_changed ? n_proposed : r_committed;
                r_out_changed <= n_changed;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_value, r_out_changed, r_out_slot};

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == ST_FILTER)
        else $error("accepted sample did not start filtering");

    a_out_from_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_DECIDE)
        else $error("result appeared outside decide step");

    a_out_matches_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        decide_go |=> r_out_slot == r_committed)
        else $error("reported slot differs from committed slot");

    a_search_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SEARCH |-> r_slot >= COUNT_BITS'(r_lo))
        else $error("search index below window start");

    a_no_change_on_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        decide_go && !r_primed |=> !r_out_changed)
        else $error("slot change flagged on priming sample");

endmodule

@@ tb/sv/analog_level_slot_detector_tb.sv @@
// Self-checking testbench for the analog level slot detector: stream stimulus, scoreboard.
`timescale 1ns / 1ps

module analog_level_slot_detector_tb;
    import alsd_pkg::*;

    localparam logic [CFG_ADDR_BITS-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SPARE_HI = 3'd7;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_ADDR_BITS-1:0]  i_cfg_addr;
    logic [CFG_DATA_BITS-1:0]  i_cfg_wdata;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [IN_TDATA_BITS-1:0]  s_axis_tdata;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;

    analog_level_slot_detector uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    typedef struct {
        logic [SLOT_BITS-1:0]   slot;
        logic                   changed;
        logic [SAMPLE_BITS-1:0] level;
    } t_slot_result;

    class slot_scoreboard;
        t_slot_result pending_results[$];
        int unsigned  fails;

        int unsigned slot_count, step_per_slot, level_offset;
        int unsigned guard_band, confirm_needed, smoothing_mode;

        int unsigned ring[WINDOW];
        int unsigned ring_ptr, ring_sum, level, proposal, committed, tally;
        bit          primed;

        function new();
            fails          = 0;
            slot_count     = RST_SLOT_COUNT;
            step_per_slot  = RST_STEP_PER_SLOT;
            level_offset   = RST_LEVEL_OFFSET;
            guard_band     = RST_GUARD_BAND;
            confirm_needed = RST_CONFIRM_NEEDED;
            smoothing_mode = RST_SMOOTHING_MODE;
            foreach (ring[i]) ring[i] = 0;
            ring_ptr  = 0;
            ring_sum  = 0;
            level     = 0;
            proposal  = 0;
            committed = 0;
            tally     = 0;
            primed    = 1'b0;
        endfunction

        function void set_reg(logic [CFG_ADDR_BITS-1:0] addr, logic [CFG_DATA_BITS-1:0] data);
            case (addr)
                REG_SLOT_COUNT:     slot_count     = data & 12'h03F;
                REG_STEP_PER_SLOT:  step_per_slot  = data;
                REG_LEVEL_OFFSET:   level_offset   = data;
                REG_GUARD_BAND:     guard_band     = data & 12'h0FF;
                REG_CONFIRM_NEEDED: confirm_needed = data & 12'h00F;
                REG_SMOOTHING_MODE: smoothing_mode = data & 12'h001;
                default: ;
            endcase
        endfunction

        function int unsigned eff_count();
            if (slot_count == 0) return 1;
            if (slot_count > MAX_SLOTS) return MAX_SLOTS;
            return slot_count;
        endfunction

        function int unsigned find_slot(int unsigned value, int unsigned lo, int unsigned hi);
            int unsigned cnt, stp, s, base, low, high;
            cnt = eff_count();
            stp = (step_per_slot == 0) ? 1 : step_per_slot;
            for (s = lo; s <= hi && s < cnt; s++) begin
                base = level_offset + stp * s;
                low  = (base >= guard_band) ? base - guard_band : 0;
                high = base + stp + guard_band;
                if (value >= low && value < high) return s;
            end
            return (value < level_offset) ? 0 : cnt - 1;
        endfunction

        function void note_sample(logic [SAMPLE_BITS-1:0] smp);
            int unsigned  x, cnt, cfm, p, avg, ema, lo, hi, cand;
            bit           changed;
            t_slot_result r;
            x       = smp;
            cnt     = eff_count();
            cfm     = (confirm_needed == 0) ? 1 : confirm_needed;
            changed = 1'b0;
            if (!primed) begin
                foreach (ring[i]) ring[i] = x;
                ring_sum  = x * WINDOW;
                ring_ptr  = 0;
                level     = x;
                committed = find_slot(level, 0, cnt - 1);
                proposal  = committed;
                tally     = cfm;
                primed    = 1'b1;
            end else begin
                p        = ring_ptr % WINDOW;
                ring_sum = ring_sum - ring[p] + x;
                ring[p]  = x;
                ring_ptr = (p + 1) % WINDOW;
                avg      = ring_sum / WINDOW;
                ema      = level - level / WINDOW + x / WINDOW;
                level    = (smoothing_mode != 0 ? ema : avg) & 12'hFFF;
                lo       = (proposal > 0) ? proposal - 1 : 0;
                hi       = (proposal + 1 < cnt) ? proposal + 1 : cnt - 1;
                cand     = (lo <= hi) ? find_slot(level, lo, hi)
                                      : ((level < level_offset) ? 0 : cnt - 1);
                if (cand == proposal) begin
                    if (tally < cfm) tally++;
                end else begin
                    proposal = cand;
                    tally    = 1;
                end
                if (tally >= cfm && proposal != committed) begin
                    committed = proposal;
                    changed   = 1'b1;
                end
            end
            r.slot    = committed[SLOT_BITS-1:0];
            r.changed = changed;
            r.level   = level[SAMPLE_BITS-1:0];
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [OUT_TDATA_BITS-1:0] tdata);
            t_slot_result w;
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected: %h", tdata);
                fails++;
                return;
            end
            w = pending_results.pop_front();
            if (tdata[4:0] !== w.slot) begin
                $error("active_slot: expected %0d, got %0d", w.slot, tdata[4:0]);
                fails++;
            end
            if (tdata[5] !== w.changed) begin
                $error("slot_changed: expected %0d, got %0d", w.changed, tdata[5]);
                fails++;
            end
            if (tdata[17:6] !== w.level) begin
                $error("smoothed_value: expected %0d, got %0d", w.level, tdata[17:6]);
                fails++;
            end
        endfunction
    endclass

    slot_scoreboard sb;
    bit quiet;
    bit hold_req;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(99, 0);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(3, 1);
        if (r < 98) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        int stall;
        stall = 0;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata);
                stall = pick_gap();
            end else if (stall == 0 && $urandom_range(15, 0) == 0) begin
                stall = pick_gap();
            end
            if (hold_req) begin
                hold_req = 1'b0;
                stall    = 400;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic put_reg(logic [CFG_ADDR_BITS-1:0] addr, int value);
        logic [CFG_DATA_BITS-1:0] m, d;
        case (addr)
            REG_SLOT_COUNT:     m = 12'h03F;
            REG_GUARD_BAND:     m = 12'h0FF;
            REG_CONFIRM_NEEDED: m = 12'h00F;
            REG_SMOOTHING_MODE: m = 12'h001;
            default:            m = 12'hFFF;
        endcase
        d = value[CFG_DATA_BITS-1:0] & m;
        if ($urandom_range(1, 0) == 1) d = d | (12'($urandom) & ~m);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= d;
        @(posedge i_clk);
        sb.set_reg(addr, d);
    endtask

    task automatic load_settings(int cnt, int stp, int ofs, int grd, int cfm, int mode);
        put_reg(REG_SLOT_COUNT, cnt);
        put_reg(REG_STEP_PER_SLOT, stp);
        put_reg(REG_LEVEL_OFFSET, ofs);
        put_reg(REG_GUARD_BAND, grd);
        put_reg(REG_CONFIRM_NEEDED, cfm);
        put_reg(REG_SMOOTHING_MODE, mode);
        put_reg(REG_SPARE_LO, $urandom);
        put_reg(REG_SPARE_HI, $urandom);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_sample(logic [SAMPLE_BITS-1:0] smp);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, smp};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_sample(smp);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic int clamp_code(int v);
        if (v < 0) return 0;
        if (v > 4095) return 4095;
        return v;
    endfunction

    function automatic int pick_target(int cnt, int stp, int ofs, int grd);
        int s;
        s = $urandom_range(cnt - 1, 0);
        case ($urandom_range(4, 0))
            0, 1:    return clamp_code(ofs + s * stp + stp / 2);
            2:       return clamp_code(ofs + s * stp + $urandom_range(2 * grd + 2, 0) - grd - 1);
            3:       return clamp_code(ofs + (s + 1) * stp + $urandom_range(2 * grd + 2, 0) - grd - 1);
            default: return $urandom_range(4095, 0);
        endcase
    endfunction

    // Dwell on target levels with jitter, broken up by bursts of noise.
    task automatic run_phase(int items, int cnt, int stp, int ofs, int grd, int hold_at);
        int n, left, lvl, jit, c, st;
        bit noise;
        c     = (cnt == 0) ? 1 : ((cnt > MAX_SLOTS) ? MAX_SLOTS : cnt);
        st    = (stp == 0) ? 1 : stp;
        jit   = (st > 640) ? 40 : st / 16;
        left  = 0;
        lvl   = 0;
        noise = 1'b0;
        for (n = 0; n < items; n++) begin
            if (left == 0) begin
                noise = ($urandom_range(9, 0) == 0);
                left  = noise ? $urandom_range(3, 1) : $urandom_range(40, 4);
                lvl   = pick_target(c, st, ofs, grd);
            end
            left--;
            if (n == hold_at) hold_req = 1'b1;
            if (noise)
                send_sample(12'($urandom_range(4095, 0)));
            else
                send_sample(12'(clamp_code(lvl + $urandom_range(2 * jit, 0) - jit)));
        end
        drain();
    endtask

    initial begin
        int cnt, stp, ofs, grd;
        sb            = new();
        quiet         = 1'b0;
        hold_req      = 1'b0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= '0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Priming sample above every slot, then clamps at both ends.
        load_settings(32, 100, 200, 10, 2, 0);
        send_sample(12'd4095);
        repeat (8) send_sample(12'd0);
        repeat (6) send_sample(12'd2048);
        send_sample(12'hAAA);
        send_sample(12'h555);
        drain();

        // Fewer slots than the proposed slot, exponential filter.
        load_settings(4, 100, 200, 255, 15, 1);
        repeat (4) send_sample(12'd1000);
        send_sample(12'd4095);
        send_sample(12'd0);
        drain();

        load_settings(32, 128, 0, 0, 1, 0);
        run_phase(125, 32, 128, 0, 0, -1);
        load_settings(63, 0, 0, 255, 15, 1);
        run_phase(125, 63, 0, 0, 255, -1);
        load_settings(0, 4095, 4095, 255, 0, 0);
        run_phase(125, 0, 4095, 4095, 255, -1);
        load_settings(32, 4095, 4095, 0, 15, 1);
        run_phase(125, 32, 4095, 4095, 0, -1);

        for (int p = 4; p < 10; p++) begin
            cnt = $urandom_range(40, 1);
            if ($urandom_range(2, 0) != 0)
                stp = 3800 / ((cnt > MAX_SLOTS) ? MAX_SLOTS : cnt) + $urandom_range(20, 0);
            else
                stp = $urandom_range(4095, 0);
            ofs   = $urandom_range(1, 0) ? $urandom_range(300, 0) : $urandom_range(4095, 0);
            grd   = $urandom_range(3, 0) != 0 ? $urandom_range(20, 0) : $urandom_range(255, 0);
            quiet = (p == 5);
            load_settings(cnt, stp, ofs, grd, $urandom_range(15, 0), $urandom_range(1, 0));
            run_phase(125, cnt, stp, ofs, grd, (p == 4) ? 30 : -1);
        end
        quiet = 1'b0;

        drain();
        repeat (50) @(posedge i_clk);
        if (sb.fails == 0 && sb.pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/alsd_pkg.sv
rtl/alsd_smoother.sv
rtl/analog_level_slot_detector.sv
tb/sv/analog_level_slot_detector_tb.sv
